### rtl/skt_pkg.sv
// Shared types and codes for the sorted key table.
package skt_pkg;

  localparam int KeyW    = 32;
  localparam int PayW    = 32;
  localparam int PosW    = 6;
  localparam int CntOutW = 7;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [PayW-1:0]        pay_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CHANGE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic     cmp_en;
    cell_op_t op;
  } cell_ctl_t;

  typedef struct packed {
    logic [CntOutW-1:0] count;
    pay_t               payload;
    logic [PosW-1:0]    position;
    status_t            status;
  } result_t;

endpackage

### rtl/sorted_key_table_core.sv
// Sorted key table: a row of compare-and-shift cells keeping key/payload pairs in order.
// Each command beat runs an accept-and-compare step, then an apply step, and no new beat
// is accepted until it is through: every cell compares its key against the command key in
// the accept cycle, and the row shifts by one slot in the apply cycle. A change-key
// command adds a second compare and shift with the new key; an insert into a full table
// skips both steps. The row has TABLE_DEPTH cells; a result beat is held in an output
// register so the next command can be accepted while it waits, and a later result stalls
// the input until that register frees. Reset clears the fill count, not the contents.
module sorted_key_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // key[31:0], new_key[63:32], payload[95:64]
  input  logic [1:0]   in_tuser,   // cmd[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata   // status[1:0], position[7:2], found_payload[39:8],
                                   // entry_count[46:40], zero[47]
);

  localparam int IdxW    = $clog2(TABLE_DEPTH);
  localparam int CntW    = $clog2(TABLE_DEPTH + 1);
  localparam int PosExtW = (IdxW > skt_pkg::PosW) ? IdxW : skt_pkg::PosW;
  localparam int CntExtW = (CntW > skt_pkg::CntOutW) ? CntW : skt_pkg::CntOutW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_APPLY = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CntW-1:0]    count_r, count_nxt;
  logic               second_r, second_nxt;
  skt_pkg::cmd_t      cmd_r;
  skt_pkg::key_t      key_r, nkey_r;
  skt_pkg::pay_t      pay_r, fpay_r, fpay_nxt;
  skt_pkg::result_t   res_r, res_nxt, res_c, out_res_r;
  logic               out_valid_r;
  logic               out_ld;
  skt_pkg::result_t   out_ld_res;

  skt_pkg::cell_ctl_t ctl;
  skt_pkg::key_t      cmp_key, ins_key;
  skt_pkg::pay_t      ins_pay;

  skt_pkg::key_t      cell_key [TABLE_DEPTH];
  skt_pkg::pay_t      cell_pay [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occ, lt, le, hit, ins;

  logic               in_acc;
  logic               out_free;
  logic               found;
  logic [IdxW-1:0]    hit_idx, ins_idx;
  skt_pkg::pay_t      hit_pay;
  logic [PosExtW-1:0] pos_ext;
  logic [CntExtW-1:0] cnt_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign ins_key = second_r ? nkey_r : key_r;
  assign ins_pay = second_r ? fpay_r : pay_r;

  // cell row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign occ[i] = count_r > CntW'(i);
    if (i == 0) begin : g_first
      skt_cell u_cell (
        .clk, .rst_n, .ctl, .occ(occ[i]), .cmp_key, .ins_key, .ins_pay,
        .lft_key(ins_key), .lft_pay(ins_pay), .lft_le(1'b1), .lft_lt(1'b1),
        .rgt_key(cell_key[(i + 1) % TABLE_DEPTH]), .rgt_pay(cell_pay[(i + 1) % TABLE_DEPTH]),
        .key_o(cell_key[i]), .pay_o(cell_pay[i]), .lt_o(lt[i]), .le_o(le[i]),
        .hit_o(hit[i]), .ins_o(ins[i])
      );
    end else if (i == TABLE_DEPTH - 1) begin : g_last
      skt_cell u_cell (
        .clk, .rst_n, .ctl, .occ(occ[i]), .cmp_key, .ins_key, .ins_pay,
        .lft_key(cell_key[i-1]), .lft_pay(cell_pay[i-1]), .lft_le(le[i-1]),
        .lft_lt(lt[i-1]), .rgt_key(cell_key[i]), .rgt_pay(cell_pay[i]),
        .key_o(cell_key[i]), .pay_o(cell_pay[i]), .lt_o(lt[i]), .le_o(le[i]),
        .hit_o(hit[i]), .ins_o(ins[i])
      );
    end else begin : g_mid
      skt_cell u_cell (
        .clk, .rst_n, .ctl, .occ(occ[i]), .cmp_key, .ins_key, .ins_pay,
        .lft_key(cell_key[i-1]), .lft_pay(cell_pay[i-1]), .lft_le(le[i-1]),
        .lft_lt(lt[i-1]), .rgt_key(cell_key[i+1]), .rgt_pay(cell_pay[i+1]),
        .key_o(cell_key[i]), .pay_o(cell_pay[i]), .lt_o(lt[i]), .le_o(le[i]),
        .hit_o(hit[i]), .ins_o(ins[i])
      );
    end
  end

  // one-hot to index and payload select
  always_comb begin
    hit_idx = '0;
    ins_idx = '0;
    hit_pay = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit[i]) hit_idx = hit_idx | IdxW'(i);
      if (ins[i]) ins_idx = ins_idx | IdxW'(i);
      hit_pay = hit_pay | (cell_pay[i] & {skt_pkg::PayW{hit[i]}});
    end
  end
  assign found = |hit;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    second_nxt = second_r;
    fpay_nxt   = fpay_r;
    res_nxt    = res_r;
    ctl.cmp_en = 1'b0;
    ctl.op     = skt_pkg::OP_HOLD;
    cmp_key    = skt_pkg::key_t'(in_tdata[31:0]);
    out_ld     = 1'b0;
    out_ld_res = res_r;
    pos_ext    = '0;
    res_c      = '0;
    cnt_ext    = CntExtW'(count_r);
    case (state_r)
      S_IDLE: begin
        second_nxt = 1'b0;
        if (in_acc) begin
          if (skt_pkg::cmd_t'(in_tuser) == skt_pkg::CMD_INSERT &&
              count_r == CntW'(TABLE_DEPTH)) begin
            cnt_ext        = CntExtW'(count_r);
            res_nxt        = '0;
            res_nxt.status = skt_pkg::ST_FULL;
            res_nxt.count  = cnt_ext[skt_pkg::CntOutW-1:0];
            state_nxt      = S_DONE;
          end else begin
            ctl.cmp_en = 1'b1;
            state_nxt  = S_APPLY;
          end
        end
      end
      S_CMP: begin
        ctl.cmp_en = 1'b1;
        cmp_key    = nkey_r;
        state_nxt  = S_APPLY;
      end
      S_APPLY: begin
        state_nxt = S_DONE;
        if (second_r) begin
          // put the rekeyed entry back after all equal keys
          ctl.op       = skt_pkg::OP_INSERT;
          count_nxt    = count_r + CntW'(1);
          pos_ext      = PosExtW'(ins_idx);
          res_c.status = skt_pkg::ST_OK;
          res_c.payload = fpay_r;
        end else begin
          case (cmd_r)
            skt_pkg::CMD_INSERT: begin
              ctl.op       = skt_pkg::OP_INSERT;
              count_nxt    = count_r + CntW'(1);
              pos_ext      = PosExtW'(ins_idx);
              res_c.status = skt_pkg::ST_OK;
            end
            default: begin
              if (!found) begin
                res_c.status = skt_pkg::ST_NOT_FOUND;
              end else begin
                res_c.status  = skt_pkg::ST_OK;
                res_c.payload = hit_pay;
                pos_ext       = PosExtW'(hit_idx);
                if (cmd_r == skt_pkg::CMD_DELETE || cmd_r == skt_pkg::CMD_CHANGE) begin
                  ctl.op    = skt_pkg::OP_DELETE;
                  count_nxt = count_r - CntW'(1);
                end
                if (cmd_r == skt_pkg::CMD_CHANGE) begin
                  second_nxt = 1'b1;
                  fpay_nxt   = hit_pay;
                  state_nxt  = S_CMP;
                end
              end
            end
          endcase
        end
        res_c.position = pos_ext[skt_pkg::PosW-1:0];
        cnt_ext        = CntExtW'(count_nxt);
        res_c.count    = cnt_ext[skt_pkg::CntOutW-1:0];
        if (state_nxt == S_DONE) begin
          if (out_free) begin
            out_ld     = 1'b1;
            out_ld_res = res_c;
            state_nxt  = S_IDLE;
          end else begin
            res_nxt = res_c;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      second_r <= second_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= skt_pkg::cmd_t'(in_tuser);
      key_r  <= skt_pkg::key_t'(in_tdata[31:0]);
      nkey_r <= skt_pkg::key_t'(in_tdata[63:32]);
      pay_r  <= in_tdata[95:64];
    end
    fpay_r <= fpay_nxt;
    res_r  <= res_nxt;
    if (out_ld) begin
      out_res_r <= out_ld_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.count, out_res_r.payload,
                       out_res_r.position, out_res_r.status};

endmodule

### rtl/skt_cell.sv
// One table slot: holds a key and payload, compares and shifts with its neighbors.
module skt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  skt_pkg::cell_ctl_t ctl,
  input  logic             occ,
  input  skt_pkg::key_t    cmp_key,
  input  skt_pkg::key_t    ins_key,
  input  skt_pkg::pay_t    ins_pay,
  input  skt_pkg::key_t    lft_key,
  input  skt_pkg::pay_t    lft_pay,
  input  logic             lft_le,
  input  logic             lft_lt,
  input  skt_pkg::key_t    rgt_key,
  input  skt_pkg::pay_t    rgt_pay,
  output skt_pkg::key_t    key_o,
  output skt_pkg::pay_t    pay_o,
  output logic             lt_o,
  output logic             le_o,
  output logic             hit_o,
  output logic             ins_o
);

  skt_pkg::key_t key_r;
  skt_pkg::pay_t pay_r;
  logic          lt_r;
  logic          le_r;
  logic          eq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      le_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      lt_r <= occ && (key_r < cmp_key);
      le_r <= occ && (key_r <= cmp_key);
      eq_r <= occ && (key_r == cmp_key);
    end
  end

  // first match sits right after the last smaller key
  assign hit_o = eq_r && lft_lt;
  // insertion slot sits right after the last key not greater
  assign ins_o = !le_r && lft_le;

  always_ff @(posedge clk) begin
    case (ctl.op)
      skt_pkg::OP_INSERT: begin
        if (ins_o) begin
          key_r <= ins_key;
          pay_r <= ins_pay;
        end else if (!le_r) begin
          key_r <= lft_key;
          pay_r <= lft_pay;
        end
      end
      skt_pkg::OP_DELETE: begin
        // close the gap: everything from the match onward moves down
        if (!lt_r) begin
          key_r <= rgt_key;
          pay_r <= rgt_pay;
        end
      end
      default: begin
      end
    endcase
  end

  assign key_o = key_r;
  assign pay_o = pay_r;
  assign lt_o  = lt_r;
  assign le_o  = le_r;

endmodule

### rtl/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
module skt_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  localparam logic [6:0] DepthMod = 7'(TABLE_DEPTH);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a command beat blocks the input for at least the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a command is in flight");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'd2 |->
      out_tdata[39:2] == '0 && out_tdata[46:40] == DepthMod)
    else $error("full status with bad fields");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'd1 |-> out_tdata[39:2] == '0)
    else $error("not-found status with nonzero position or payload");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> TABLE_DEPTH > 127 || out_tdata[46:40] <= DepthMod)
    else $error("entry count beyond table depth");

endmodule

bind sorted_key_table_core skt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_skt_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);

### test/tb_sorted_key_table_core.sv
// Stream-level testbench for the sorted key table: directed and random commands checked against a shadow table.
module tb_sorted_key_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int            DEPTH   = 64;
  localparam skt_pkg::key_t KEY_MIN = 32'h8000_0000;
  localparam skt_pkg::key_t KEY_MAX = 32'h7FFF_FFFF;

  typedef struct {
    skt_pkg::cmd_t op;
    skt_pkg::key_t key;
    skt_pkg::key_t new_key;
    skt_pkg::pay_t payload;
    bit            wait_empty;  // hold this beat until every reply is back
  } table_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;    // key[31:0], new_key[63:32], payload[95:64]
  logic [1:0]  in_tuser = '0;    // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // status[1:0], position[7:2], found_payload[39:8],
                                 // entry_count[46:40], zero[47]

  sorted_key_table_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the table contents.
  skt_pkg::key_t tbl_key [DEPTH];
  skt_pkg::pay_t tbl_pay [DEPTH];
  int   tbl_fill = 0;
  int   tbl_peak = 0;

  table_cmd_t        queued_cmds [$];
  skt_pkg::result_t  owed_replies [$];
  skt_pkg::key_t     key_pool [16];

  int unsigned errors = 0;
  int          accepted_cnt = 0;
  int          n_ok = 0, n_missing = 0, n_full = 0;
  bit          in_taken = 1'b0, out_taken = 1'b0;
  int          send_gap = 0, recv_gap = 0, hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** sorted_key_table_core: FAILED **");
    $display("timeout: %0d commands accepted, %0d replies pending",
             accepted_cnt, owed_replies.size());
    $finish;
  end

  // Mostly short gaps, a few long ones; none during the calm stretches.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if ((accepted_cnt % 200) >= 150) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // First slot holding a key greater than k: new entries go after equal keys.
  function automatic int slot_after(skt_pkg::key_t k);
    int i;
    i = 0;
    while (i < tbl_fill && tbl_key[i] <= k) i++;
    return i;
  endfunction

  function automatic void put_entry(int idx, skt_pkg::key_t k, skt_pkg::pay_t p);
    for (int i = tbl_fill; i > idx; i--) begin
      tbl_key[i] = tbl_key[i-1];
      tbl_pay[i] = tbl_pay[i-1];
    end
    tbl_key[idx] = k;
    tbl_pay[idx] = p;
    tbl_fill++;
    if (tbl_fill > tbl_peak) tbl_peak = tbl_fill;
  endfunction

  function automatic void take_entry(int idx);
    for (int i = idx; i + 1 < tbl_fill; i++) begin
      tbl_key[i] = tbl_key[i+1];
      tbl_pay[i] = tbl_pay[i+1];
    end
    tbl_fill--;
  endfunction

  function automatic skt_pkg::result_t apply_to_table(skt_pkg::cmd_t op, skt_pkg::key_t k,
                                                      skt_pkg::key_t nk, skt_pkg::pay_t p);
    skt_pkg::result_t r;
    int               idx;
    r = '0;
    r.status = skt_pkg::ST_OK;
    if (op == skt_pkg::CMD_INSERT) begin
      if (tbl_fill >= DEPTH) begin
        r.status = skt_pkg::ST_FULL;
      end else begin
        idx = slot_after(k);
        put_entry(idx, k, p);
        r.position = idx[5:0];
      end
    end else begin
      // lowest slot whose key is not below k
      idx = 0;
      while (idx < tbl_fill && tbl_key[idx] < k) idx++;
      if (idx >= tbl_fill || tbl_key[idx] != k) begin
        r.status = skt_pkg::ST_NOT_FOUND;
      end else begin
        r.payload  = tbl_pay[idx];
        r.position = idx[5:0];
        if (op != skt_pkg::CMD_LOOKUP) take_entry(idx);
        if (op == skt_pkg::CMD_CHANGE) begin
          idx = slot_after(nk);
          put_entry(idx, nk, r.payload);
          r.position = idx[5:0];
        end
      end
    end
    r.count = tbl_fill[6:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Sample both channels at the rising edge.
  always @(posedge clk) begin : watch
    skt_pkg::result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[46:0];
      if (owed_replies.size() == 0) begin
        $error("reply beat with nothing outstanding: 0x%0h", out_tdata);
        errors++;
      end else begin
        want = owed_replies.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("position", 32'(want.position), 32'(got.position));
        check_field("found_payload", want.payload, got.payload);
        check_field("entry_count", 32'(want.count), 32'(got.count));
        case (got.status)
          skt_pkg::ST_OK:        n_ok++;
          skt_pkg::ST_NOT_FOUND: n_missing++;
          default:               n_full++;
        endcase
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      owed_replies.push_back(apply_to_table(skt_pkg::cmd_t'(in_tuser), in_tdata[31:0],
                                            in_tdata[63:32], in_tdata[95:64]));
      accepted_cnt++;
    end
    in_taken  <= rst_n && in_tvalid && in_tready;
    out_taken <= rst_n && out_tvalid && out_tready;
  end

  // Command driver: advance at the falling edge once the current beat is taken.
  always @(negedge clk) begin : drive
    table_cmd_t nxt;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (queued_cmds.size() > 0 &&
                   !(queued_cmds[0].wait_empty && owed_replies.size() > 0)) begin
        nxt = queued_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.op;
        in_tdata  <= {nxt.payload, nxt.new_key, nxt.key};
        send_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Reply sink: random stalls after each beat, plus one long hold-off.
  always @(negedge clk) begin : sink
    if (rst_n) begin
      if (!hold_done && accepted_cnt >= 150) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (out_taken) recv_gap = pick_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void add_cmd(skt_pkg::cmd_t op, skt_pkg::key_t k, skt_pkg::key_t nk,
                                  skt_pkg::pay_t p, bit wait_empty);
    table_cmd_t c;
    c.op = op;
    c.key = k;
    c.new_key = nk;
    c.payload = p;
    c.wait_empty = wait_empty;
    queued_cmds.push_back(c);
  endfunction

  // mode 0 leans to inserts, 1 is even, 2 leans to deletes
  function automatic skt_pkg::cmd_t pick_cmd(int mode);
    int unsigned r;
    int          ins, look, del;
    r = $urandom_range(99, 0);
    case (mode)
      0:       begin ins = 70; look = 80; del = 90; end
      1:       begin ins = 25; look = 50; del = 75; end
      default: begin ins = 10; look = 30; del = 80; end
    endcase
    if (r < ins) return skt_pkg::CMD_INSERT;
    if (r < look) return skt_pkg::CMD_LOOKUP;
    if (r < del) return skt_pkg::CMD_DELETE;
    return skt_pkg::CMD_CHANGE;
  endfunction

  // Pool keys make hits and repeated keys common.
  function automatic skt_pkg::key_t pick_key();
    if ($urandom_range(99, 0) < 70) return key_pool[$urandom_range(15, 0)];
    return skt_pkg::key_t'($urandom);
  endfunction

  initial begin : stimulus
    skt_pkg::cmd_t op;

    // empty table
    add_cmd(skt_pkg::CMD_LOOKUP, 0, 0, 0, 0);
    add_cmd(skt_pkg::CMD_DELETE, KEY_MIN, 0, 0, 0);
    add_cmd(skt_pkg::CMD_CHANGE, KEY_MAX, 0, 0, 0);
    // extremes and repeated keys
    add_cmd(skt_pkg::CMD_INSERT, 0, 0, 32'h0000_0000, 0);
    add_cmd(skt_pkg::CMD_INSERT, KEY_MAX, 0, 32'hFFFF_FFFF, 0);
    add_cmd(skt_pkg::CMD_INSERT, KEY_MIN, KEY_MAX, 32'h0000_0001, 0);
    add_cmd(skt_pkg::CMD_INSERT, 0, 0, 32'hA5A5_A5A5, 0);
    add_cmd(skt_pkg::CMD_INSERT, -1, 0, 32'h5A5A_5A5A, 0);
    add_cmd(skt_pkg::CMD_INSERT, KEY_MAX, 0, 32'h0000_0002, 0);
    add_cmd(skt_pkg::CMD_LOOKUP, 0, 0, 0, 0);
    add_cmd(skt_pkg::CMD_LOOKUP, KEY_MIN, 0, 0, 0);
    add_cmd(skt_pkg::CMD_LOOKUP, KEY_MAX, 0, 0, 0);
    add_cmd(skt_pkg::CMD_LOOKUP, 7, 0, 0, 0);
    // rekey moves the entry behind equal keys
    add_cmd(skt_pkg::CMD_CHANGE, 0, KEY_MAX, 0, 0);
    add_cmd(skt_pkg::CMD_CHANGE, KEY_MIN, KEY_MIN, 0, 0);
    add_cmd(skt_pkg::CMD_CHANGE, -1, KEY_MIN, 0, 0);
    add_cmd(skt_pkg::CMD_DELETE, KEY_MAX, 0, 0, 0);
    add_cmd(skt_pkg::CMD_DELETE, 7, 0, 0, 0);
    add_cmd(skt_pkg::CMD_CHANGE, 7, 0, 0, 0);
    add_cmd(skt_pkg::CMD_DELETE, KEY_MIN, 0, 0, 0);
    add_cmd(skt_pkg::CMD_LOOKUP, 0, 0, 0, 0);
    add_cmd(skt_pkg::CMD_INSERT, -2, 0, 32'hDEAD_0001, 0);

    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 0;
    key_pool[3] = -1;
    // fill, mixed and drain phases; fill phases open with a run of inserts
    // long enough to overflow the table
    for (int ph = 0; ph < 6; ph++) begin
      for (int s = 4; s < 16; s++) key_pool[s] = skt_pkg::key_t'($urandom);
      for (int i = 0; i < 100; i++) begin
        if (ph % 3 == 0 && i < 70) op = skt_pkg::CMD_INSERT;
        else op = pick_cmd(ph % 3);
        add_cmd(op, pick_key(), pick_key(), skt_pkg::pay_t'($urandom),
                i == 0 && (ph == 0 || ph == 3));
      end
    end

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    while (queued_cmds.size() > 0 || in_tvalid || owed_replies.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d commands: %0d ok, %0d key not found, %0d refused on a full table.",
             accepted_cnt, n_ok, n_missing, n_full);
    $display("Table fill peaked at %0d of %0d entries.", tbl_peak, DEPTH);
    if (errors == 0) begin
      $display("** sorted_key_table_core: PASSED **");
    end else begin
      $display("** sorted_key_table_core: FAILED **");
    end
    $finish;
  end

endmodule
